/* rtl/go_back_n_sender_assert.svh */
// ----------------------------------------------------------------------------
// Go-Back-N sender assertion macros
// Shared assertion macros for the Go-Back-N sender; they compile away
// when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_ASSERT_SVH
`define GO_BACK_N_SENDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define GBN_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("go_back_n_sender: assertion failed");

`define GBN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("go_back_n_sender: assertion failed");

`else

`define GBN_ASSERT_SAME(label, ante, cons)

`define GBN_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Codes, widths and types shared by the sender and its arithmetic unit.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int SEQ_W      = 8;
    localparam int RESULT_CAP = 16;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_ACK   = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [1:0] KIND_INIT   = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_GIVEUP = 2'd2;

    localparam logic       CFG_TIMEOUT = 1'b0;
    localparam logic       CFG_RETRY   = 1'b1;

    localparam logic [7:0] TIMEOUT_RESET = 8'd5;
    localparam logic [3:0] RETRY_RESET   = 4'd3;
    localparam logic [7:0] SEQ_WRAP      = 8'd255;

    typedef logic [1:0] alu_op_t;

    localparam alu_op_t ALU_INC = 2'd0;
    localparam alu_op_t ALU_SUB = 2'd1;
    localparam alu_op_t ALU_DEC = 2'd2;

    typedef struct packed {
        logic             carry;
        logic [SEQ_W-1:0] sum;
    } alu_res_t;

endpackage

/* rtl/gbn_alu.sv */
// ----------------------------------------------------------------------------
// Go-Back-N sender arithmetic unit
// One 8-bit adder shared by the sequencer for increments, decrements,
// subtraction and comparison; carry set on a subtraction means no borrow.
// ----------------------------------------------------------------------------
module gbn_alu (
    input  gbn_pkg::alu_op_t          op,
    input  logic [gbn_pkg::SEQ_W-1:0] a,
    input  logic [gbn_pkg::SEQ_W-1:0] b,
    output gbn_pkg::alu_res_t         res
);

    logic [gbn_pkg::SEQ_W:0] total;

    always_comb
    begin
        case (op)
            gbn_pkg::ALU_INC: total = {1'b0, a} + 9'd1;
            gbn_pkg::ALU_SUB: total = {1'b0, a} + {1'b0, ~b} + 9'd1;
            gbn_pkg::ALU_DEC: total = {1'b0, a} + 9'h0FF;
            default:          total = '0;
        endcase
        res.carry = total[gbn_pkg::SEQ_W];
        res.sum   = total[gbn_pkg::SEQ_W-1:0];
    end

endmodule

/* rtl/go_back_n_sender.sv */
// ----------------------------------------------------------------------------
// Go-Back-N sender
// Sender side of a Go-Back-N exchange with a tick timer and retry budget.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel: tuser carries the function (start,
// acknowledgement, timer tick), tdata the acknowledged number and window size.
// Packets leave on the m_axis channel: tuser is the packet kind, tdata the
// sequence number, and tlast marks the final beat caused by an input item.
// The cfg channel writes the timeout in ticks (index 0) and the retry limit
// (index 1); it is always ready and should only be used while idle.
// The input is ready only while the sequencer is idle. A start or an
// acknowledgement goes through the emit state and then sends its packets.
// A tick on a running timer goes through the increment and compare states,
// one on a stopped timer does nothing, and a timeout may step the base
// back via the subtract and fix states before emission, on the one shared adder.
// Packets pass through a single output register; when the receiver stalls,
// emission waits on that register and the input stays not ready.
// Reset clears the sequence state, stops the timer and restores the timeout
// to five ticks and the retry limit to three; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_assert.svh"

module go_back_n_sender #(
    parameter int MAX_WINDOW = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] ack_no, [12:8] window_size, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] seq_no
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int WIN_CAP = (MAX_WINDOW < gbn_pkg::RESULT_CAP) ? MAX_WINDOW
                                                                : gbn_pkg::RESULT_CAP;
    localparam int WIN_W   = $clog2(WIN_CAP + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_TICK_INC  = 4'd1;
    localparam logic [3:0] S_TICK_CMP  = 4'd2;
    localparam logic [3:0] S_SUB       = 4'd3;
    localparam logic [3:0] S_FIX       = 4'd4;
    localparam logic [3:0] S_EMIT      = 4'd5;
    localparam logic [3:0] S_EMIT_INIT = 4'd6;
    localparam logic [3:0] S_EMIT_DATA = 4'd7;
    localparam logic [3:0] S_GIVEUP    = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [7:0]       timeout_reg, timeout_next;
    logic [3:0]       retry_limit_reg, retry_limit_next;
    logic [7:0]       base_reg, base_next;
    logic [WIN_W-1:0] window_reg, window_next;
    logic             init_sent_reg, init_sent_next;
    logic [3:0]       retries_reg, retries_next;
    logic [7:0]       tick_reg, tick_next;
    logic             armed_reg, armed_next;
    logic [WIN_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_kind_reg, out_kind_next;
    logic [7:0]       out_seq_reg, out_seq_next;
    logic             out_last_reg, out_last_next;

    gbn_pkg::alu_op_t  alu_op;
    logic [7:0]        alu_a, alu_b;
    gbn_pkg::alu_res_t alu_res;

    logic       slot_free;
    logic [7:0] limit;
    logic [1:0] in_func;
    logic [7:0] in_ack;
    logic [4:0] in_wsz;

    assign in_func   = s_axis_tuser;
    assign in_ack    = s_axis_tdata[7:0];
    assign in_wsz    = s_axis_tdata[12:8];
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign limit     = (timeout_reg == 8'd0) ? 8'd1 : timeout_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_seq_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    gbn_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    always_comb
    begin
        alu_op = gbn_pkg::ALU_INC;
        alu_a  = base_reg;
        alu_b  = 8'd0;
        case (state_reg)
            S_TICK_INC:
            begin
                alu_a = tick_reg;
            end
            S_TICK_CMP:
            begin
                alu_op = gbn_pkg::ALU_SUB;
                alu_a  = tick_reg;
                alu_b  = limit;
            end
            S_SUB:
            begin
                alu_op = gbn_pkg::ALU_SUB;
                alu_b  = 8'(window_reg);
            end
            S_FIX:
            begin
                alu_op = gbn_pkg::ALU_DEC;
            end
            default:
            begin
                alu_op = gbn_pkg::ALU_INC;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        timeout_next     = timeout_reg;
        retry_limit_next = retry_limit_reg;
        base_next        = base_reg;
        window_next      = window_reg;
        init_sent_next   = init_sent_reg;
        retries_next     = retries_reg;
        tick_next        = tick_reg;
        armed_next       = armed_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_kind_next    = out_kind_reg;
        out_seq_next     = out_seq_reg;
        out_last_next    = out_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == gbn_pkg::CFG_TIMEOUT)
            begin
                timeout_next = cfg_data;
            end
            else
            begin
                retry_limit_next = cfg_data[3:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (in_func)
                        gbn_pkg::FUNC_START:
                        begin
                            state_next = S_EMIT;
                        end
                        gbn_pkg::FUNC_ACK:
                        begin
                            if (in_ack == 8'd0)
                            begin
                                window_next = (in_wsz > 5'(WIN_CAP)) ? WIN_W'(WIN_CAP)
                                                                     : WIN_W'(in_wsz);
                            end
                            else
                            begin
                                base_next = (in_ack == gbn_pkg::SEQ_WRAP) ? 8'd0 : in_ack;
                            end
                            retries_next = retry_limit_reg;
                            state_next   = S_EMIT;
                        end
                        gbn_pkg::FUNC_TICK:
                        begin
                            if (armed_reg)
                            begin
                                state_next = S_TICK_INC;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TICK_INC:
            begin
                tick_next  = alu_res.sum;
                state_next = S_TICK_CMP;
            end
            S_TICK_CMP:
            begin
                if (alu_res.carry)
                begin
                    tick_next = 8'd0;
                    if (retries_reg != 4'd0)
                    begin
                        retries_next = retries_reg - 4'd1;
                        if (base_reg == 8'd0)
                        begin
                            init_sent_next = 1'b0;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_SUB;
                        end
                    end
                    else
                    begin
                        state_next = S_GIVEUP;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SUB:
            begin
                base_next  = alu_res.sum;
                state_next = alu_res.carry ? S_EMIT : S_FIX;
            end
            S_FIX:
            begin
                base_next  = alu_res.sum;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                tick_next  = 8'd0;
                armed_next = 1'b1;
                cnt_next   = window_reg;
                if (!init_sent_reg)
                begin
                    state_next = S_EMIT_INIT;
                end
                else if (window_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT_DATA;
                end
            end
            S_EMIT_INIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = gbn_pkg::KIND_INIT;
                    out_seq_next   = base_reg;
                    out_last_next  = 1'b1;
                    init_sent_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = gbn_pkg::KIND_DATA;
                    out_seq_next   = alu_res.sum;
                    out_last_next  = (cnt_reg == WIN_W'(1));
                    base_next      = (alu_res.sum == gbn_pkg::SEQ_WRAP) ? 8'd0 : alu_res.sum;
                    cnt_next       = cnt_reg - WIN_W'(1);
                    if (cnt_reg == WIN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_GIVEUP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = gbn_pkg::KIND_GIVEUP;
                    out_seq_next   = 8'd0;
                    out_last_next  = 1'b1;
                    armed_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            timeout_reg     <= gbn_pkg::TIMEOUT_RESET;
            retry_limit_reg <= gbn_pkg::RETRY_RESET;
            base_reg        <= 8'd0;
            window_reg      <= '0;
            init_sent_reg   <= 1'b0;
            retries_reg     <= gbn_pkg::RETRY_RESET;
            tick_reg        <= 8'd0;
            armed_reg       <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            timeout_reg     <= timeout_next;
            retry_limit_reg <= retry_limit_next;
            base_reg        <= base_next;
            window_reg      <= window_next;
            init_sent_reg   <= init_sent_next;
            retries_reg     <= retries_next;
            tick_reg        <= tick_next;
            armed_reg       <= armed_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_seq_reg  <= out_seq_next;
        out_last_reg <= out_last_next;
    end

    `GBN_ASSERT_SAME(a_window_capped, 1'b1, window_reg <= WIN_W'(WIN_CAP))
    `GBN_ASSERT_SAME(a_base_below_wrap, 1'b1, base_reg != gbn_pkg::SEQ_WRAP)
    `GBN_ASSERT_SAME(a_count_live, state_reg == S_EMIT_DATA, cnt_reg != '0)
    `GBN_ASSERT_NEXT(a_giveup_beat, (state_reg == S_GIVEUP) && slot_free,
                     m_axis_tvalid && m_axis_tlast
                     && (m_axis_tuser == gbn_pkg::KIND_GIVEUP) && !armed_reg)

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Go-Back-N sender testbench
// Drives start, acknowledgement and tick items into the sender while both
// stream sides idle at random. Each accepted item is run through a
// behavioural copy of the sender state, and every packet that leaves the block
// is compared field by field with the oldest packet still due. A short
// directed table covers the edge cases. Six randomised phases follow, each
// with its own timeout and retry setting, and one of them includes a long
// receiver stall.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WIN_CAP = gbn_pkg::RESULT_CAP;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 42;
    localparam int LONG_HOLD = 400;
    localparam int N_DIRECTED = 22;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] seq;
        logic       last;
    } packet_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t  act;
        logic [1:0] func;
        logic [7:0] ack;
        logic [4:0] wsz;
        logic [7:0] tmo;
        logic [7:0] rty;
        logic       chk;
        logic [1:0] kind;
        logic [7:0] seq;
    } step_t;

    localparam step_t DIRECTED [N_DIRECTED] = '{
        '{ROW_ITEM, gbn_pkg::FUNC_TICK,  8'd0,   5'd0,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, FUNC_UNUSED,         8'd0,   5'd0,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_START, 8'd0,   5'd0,  8'd0,   8'd0,
          1'b1, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_ACK,   8'd0,   5'd0,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_ACK,   8'd0,   5'd31, 8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_ACK,   8'd250, 5'd0,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_ACK,   8'd255, 5'd0,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_ACK,   8'd0,   5'd2,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_CFG,  gbn_pkg::FUNC_START, 8'd0,   5'd0,  8'd0,   8'hF1,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_ACK,   8'd0,   5'd2,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_TICK,  8'd0,   5'd0,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_TICK,  8'd0,   5'd0,  8'd0,   8'd0,
          1'b1, gbn_pkg::KIND_GIVEUP, 8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_TICK,  8'd0,   5'd0,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_ACK,   8'd0,   5'd0,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_ACK,   8'd255, 5'd0,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_TICK,  8'd0,   5'd0,  8'd0,   8'd0,
          1'b1, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_TICK,  8'd0,   5'd0,  8'd0,   8'd0,
          1'b1, gbn_pkg::KIND_GIVEUP, 8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_START, 8'd0,   5'd0,  8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_CFG,  gbn_pkg::FUNC_START, 8'd0,   5'd0,  8'd255, 8'h0F,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_ACK,   8'd0,   5'd16, 8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, gbn_pkg::FUNC_TICK,  8'd255, 5'd31, 8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0},
        '{ROW_ITEM, FUNC_UNUSED,         8'd255, 5'd31, 8'd0,   8'd0,
          1'b0, gbn_pkg::KIND_INIT,   8'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] ack_no, [12:8] window_size, rest zero
    logic [1:0]  s_axis_tuser = '0;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] seq_no
    logic [1:0]  m_axis_tuser;        // [1:0] kind
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = gbn_pkg::CFG_TIMEOUT;
    logic [7:0]  cfg_data = '0;

    logic        offer_checked = 1'b0;
    logic [1:0]  offer_kind = gbn_pkg::KIND_INIT;
    logic [7:0]  offer_seq = '0;

    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    int          rx_hold = 0;
    int          errors = 0;
    int          cycles = 0;

    logic [7:0]  base_no = '0;
    logic [4:0]  win_len = '0;
    logic        init_done = 1'b0;
    logic [3:0]  retries = gbn_pkg::RETRY_RESET;
    logic [7:0]  ticks = '0;
    logic        timer_on = 1'b0;
    logic [7:0]  timeout_reg = gbn_pkg::TIMEOUT_RESET;
    logic [3:0]  retry_reg = gbn_pkg::RETRY_RESET;

    packet_t     fresh[$];
    packet_t     packets_due[$];

    go_back_n_sender #(.MAX_WINDOW(WIN_CAP)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function void send_packets();
        logic [8:0] nb;
        if (!init_done)
        begin
            init_done = 1'b1;
            fresh.push_back({gbn_pkg::KIND_INIT, base_no, 1'b0});
        end
        else
        begin
            for (int k = 0; k < win_len; k++)
            begin
                nb = {1'b0, base_no} + 9'd1;
                fresh.push_back({gbn_pkg::KIND_DATA, nb[7:0], 1'b0});
                base_no = (nb >= 9'd255) ? 8'd0 : nb[7:0];
            end
        end
    endfunction

    function void restart_timer();
        ticks = '0;
        timer_on = 1'b1;
    endfunction

    function void predict_packets(input logic [1:0] func, input logic [7:0] ack,
                                  input logic [4:0] wsz);
        logic [7:0] limit;
        int         back;
        packet_t    tail;
        fresh.delete();
        case (func)
            gbn_pkg::FUNC_START:
            begin
                send_packets();
                restart_timer();
            end
            gbn_pkg::FUNC_ACK:
            begin
                if (ack == 8'd0)
                    win_len = (wsz > WIN_CAP) ? 5'(WIN_CAP) : wsz;
                else
                    base_no = (ack == gbn_pkg::SEQ_WRAP) ? 8'd0 : ack;
                retries = retry_reg;
                send_packets();
                restart_timer();
            end
            gbn_pkg::FUNC_TICK:
            begin
                if (timer_on)
                begin
                    limit = (timeout_reg == 8'd0) ? 8'd1 : timeout_reg;
                    ticks = ticks + 8'd1;
                    if (ticks >= limit)
                    begin
                        ticks = '0;
                        if (retries != 4'd0)
                        begin
                            retries = retries - 4'd1;
                            if (base_no == 8'd0)
                                init_done = 1'b0;
                            else
                            begin
                                back = (int'(base_no) % 255 + 255 - int'(win_len)) % 255;
                                base_no = back[7:0];
                            end
                            send_packets();
                            restart_timer();
                        end
                        else
                        begin
                            fresh.push_back({gbn_pkg::KIND_GIVEUP, 8'd0, 1'b0});
                            timer_on = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (fresh.size() != 0)
        begin
            tail = fresh.pop_back();
            tail.last = 1'b1;
            fresh.push_back(tail);
        end
    endfunction

    task report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin : beat_monitor
        packet_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == gbn_pkg::CFG_TIMEOUT)
                    timeout_reg = cfg_data;
                else
                    retry_reg = cfg_data[3:0];
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (packets_due.size() == 0)
                    report($sformatf("packet seq_no %0d with nothing due", m_axis_tdata));
                else
                begin
                    want = packets_due.pop_front();
                    if (m_axis_tuser !== want.kind)
                        report($sformatf("kind %0d, expected %0d", m_axis_tuser, want.kind));
                    if (m_axis_tdata !== want.seq)
                        report($sformatf("seq_no %0d, expected %0d", m_axis_tdata, want.seq));
                    if (m_axis_tlast !== want.last)
                        report($sformatf("last %0d, expected %0d", m_axis_tlast, want.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_packets(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[12:8]);
                if (offer_checked)
                    packets_due.push_back({offer_kind, offer_seq, 1'b1});
                else
                    foreach (fresh[i])
                        packets_due.push_back(fresh[i]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // The receiver may stall at random before each beat; a long hold request fills the
    // block up so that it has to refuse further input.
    initial
    begin : receiver
        int pause;
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                pause = rx_hold;
                rx_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            pause = rx_calm ? 0 : $urandom_range(0, 15);
            if (pause > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid && rx_hold == 0);
        end
    end

    task offer_beat(input logic [1:0] func, input logic [7:0] ack, input logic [4:0] wsz,
                    input logic chk, input logic [1:0] kind, input logic [7:0] seq);
        int pause;
        pause = tx_calm ? 0 : $urandom_range(0, 15);
        if (pause > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, wsz, ack};
        s_axis_tuser <= func;
        offer_checked <= chk;
        offer_kind <= kind;
        offer_seq <= seq;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Ticks that produce no packet may still be in flight once the queue
    // drains, so the task goes on waiting for a settling period before the block counts as idle.
    task settle();
        s_axis_tvalid <= 1'b0;
        while (packets_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_registers(input logic [7:0] tmo, input logic [7:0] rty);
        cfg_valid <= 1'b1;
        cfg_index <= gbn_pkg::CFG_TIMEOUT;
        cfg_data <= tmo;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= gbn_pkg::CFG_RETRY;
        cfg_data <= rty;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int         pick;
        logic [1:0] func;
        logic [7:0] ack;
        logic [4:0] wsz;
        logic [7:0] tmo;
        logic [7:0] rty;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].act == ROW_CFG)
            begin
                settle();
                write_registers(DIRECTED[i].tmo, DIRECTED[i].rty);
            end
            else
                offer_beat(DIRECTED[i].func, DIRECTED[i].ack, DIRECTED[i].wsz,
                           DIRECTED[i].chk, DIRECTED[i].kind, DIRECTED[i].seq);
        end
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: begin tmo = 8'd1;   rty = 8'h00; end
                1: begin tmo = 8'd2;   rty = 8'h0F; end
                2: begin tmo = 8'd255; rty = 8'h03; end
                3: begin tmo = 8'd3;   rty = 8'hA5; end
                4: begin tmo = 8'($urandom_range(1, 6)); rty = 8'($urandom_range(0, 255)); end
                default: begin tmo = gbn_pkg::TIMEOUT_RESET; rty = 8'h5C; end
            endcase
            write_registers(tmo, rty);
            tx_calm = (p == 1) || (p == 4);
            rx_calm = (p == 3) || (p == 5);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 1 && n == 10)
                    rx_hold = LONG_HOLD;
                if (p == 3 && n == 20)
                    settle();
                pick = $urandom_range(0, 99);
                ack = 8'($urandom_range(0, 255));
                wsz = 5'($urandom_range(0, 31));
                if (pick < 4)
                    func = gbn_pkg::FUNC_START;
                else if (pick < 14)
                begin
                    func = gbn_pkg::FUNC_ACK;
                    ack = 8'd0;
                    if ($urandom_range(0, 7) != 0)
                        wsz = 5'($urandom_range(0, 6));
                end
                else if (pick < 34)
                begin
                    func = gbn_pkg::FUNC_ACK;
                    if (ack == 8'd0)
                        ack = gbn_pkg::SEQ_WRAP;
                end
                else if (pick < 96)
                    func = gbn_pkg::FUNC_TICK;
                else
                    func = FUNC_UNUSED;
                offer_beat(func, ack, wsz, 1'b0, gbn_pkg::KIND_INIT, 8'd0);
            end
        end
        settle();
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
